FILE: rtl/tpsc_pkg.sv
// Package for the two-point sensor calibration block: field widths, register
// map, calibration register bundle, lane control struct and pipeline sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpsc_pkg;

   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int FRACTION_BITS_MIN     = 4;
   localparam int FRACTION_BITS_MAX     = 12;

   localparam int RAW_W            = 16;
   localparam int HUM_PCT_W        = 7;
   localparam int TEMP_X8_W        = 10;
   localparam int POINT_W          = 10;
   localparam int TEMP_POINT_SHIFT = 3;
   localparam int HUM_FULL_SCALE   = 100;

   localparam int DY_W   = POINT_W + 1;
   localparam int DX_W   = RAW_W + 1;
   localparam int PROD_W = DY_W + DX_W;
   localparam int PMAG_W = POINT_W + RAW_W;
   localparam int DEN_W  = RAW_W;
   localparam int OUT_W  = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // stages outside the divider steps: subtract, multiply, scale,
   // divider load, offset add, clamp
   localparam int PIPE_FIXED_STAGES = 6;

   localparam logic ACTION_TEMPERATURE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUM_POINT0_PCT  = 3'd0,
      CSR_HUM_POINT1_PCT  = 3'd1,
      CSR_HUM_POINT0_RAW  = 3'd2,
      CSR_HUM_POINT1_RAW  = 3'd3,
      CSR_TEMP_POINT0_X8  = 3'd4,
      CSR_TEMP_POINT1_X8  = 3'd5,
      CSR_TEMP_POINT0_RAW = 3'd6,
      CSR_TEMP_POINT1_RAW = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        [HUM_PCT_W-1:0] hum_point0_pct;
      logic        [HUM_PCT_W-1:0] hum_point1_pct;
      logic signed [RAW_W-1:0]     hum_point0_raw;
      logic signed [RAW_W-1:0]     hum_point1_raw;
      logic        [TEMP_X8_W-1:0] temp_point0_x8;
      logic        [TEMP_X8_W-1:0] temp_point1_x8;
      logic signed [RAW_W-1:0]     temp_point0_raw;
      logic signed [RAW_W-1:0]     temp_point1_raw;
   } cal_cfg_type;

   localparam cal_cfg_type CFG_RESET = '{
      hum_point0_pct:  7'd0,
      hum_point1_pct:  7'd100,
      hum_point0_raw:  16'sd0,
      hum_point1_raw:  16'sd1,
      temp_point0_x8:  10'd0,
      temp_point1_x8:  10'd8,
      temp_point0_raw: 16'sd0,
      temp_point1_raw: 16'sd1
   };

   // control bits that travel with each request down the pipe
   typedef struct packed {
      logic action;
      logic bad;
      logic qneg;
      logic ovf;
   } lane_ctl_type;

   // quotient bits kept: enough headroom above the scaled offset that a
   // capped quotient still saturates in the right direction
   function automatic int quot_width(input int fraction_bits);
      int span;
      span = (fraction_bits + HUM_PCT_W > OUT_W - 1) ? fraction_bits + HUM_PCT_W : OUT_W - 1;
      return span + 2;
   endfunction

   function automatic int pipe_latency(input int fraction_bits);
      return quot_width(fraction_bits) + PIPE_FIXED_STAGES;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/two_point_sensor_calibration.sv
// Top level of the two-point sensor calibration block.
// Depends on tpsc_pkg, tpsc_csr, tpsc_prep, tpsc_div and tpsc_post.
//
// Usage:
//   Configuration: write the eight calibration points through csr_we,
//   csr_index and csr_wdata; a write lands at the clock edge where csr_we is
//   high. Write only while no request is in flight.
//   Requests: drive req_action (0 humidity, 1 temperature) and req_raw_sample
//   with start high; the request is taken at an edge where busy is low.
//   busy is low at all times outside reset, so one request per cycle is taken.
//   Results: rsp_valid strobes for one cycle with rsp_calibrated_value (Q-format
//   with FRACTION_BITS fraction bits), rsp_limited and rsp_divide_error.
//   Pipeline depth is set by the divider, which retires one quotient bit per
//   stage; the other six stages are difference, multiply, scale, divider
//   load, offset add and clamp/saturate.
//   Throughput: one request per cycle, results in request order.
//   Reset: synchronous; flushes every request in flight and restores the
//   calibration registers to their defaults. busy is high during reset.
//   The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module two_point_sensor_calibration #(
   parameter int FRACTION_BITS = tpsc_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_action,
   input  wire logic signed [tpsc_pkg::RAW_W-1:0]   req_raw_sample,
   // result channel
   output logic                                     rsp_valid,
   output logic signed [tpsc_pkg::OUT_W-1:0]        rsp_calibrated_value,
   output logic                                     rsp_limited,
   output logic                                     rsp_divide_error,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [tpsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tpsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int QUOT_W = tpsc_pkg::quot_width(FRACTION_BITS);
   localparam int NUM_W  = tpsc_pkg::PMAG_W + FRACTION_BITS;
   localparam int Y0S_W  = tpsc_pkg::HUM_PCT_W + FRACTION_BITS;

   tpsc_pkg::cal_cfg_type          cfg;
   logic                           accept;

   logic                           prep_valid;
   logic [NUM_W-1:0]               prep_num;
   logic [tpsc_pkg::DEN_W-1:0]     prep_dmag;
   logic [Y0S_W-1:0]               prep_y0s;
   tpsc_pkg::lane_ctl_type         prep_ctl;

   logic                           div_valid;
   logic [QUOT_W-1:0]              div_quot;
   logic [Y0S_W-1:0]               div_y0s;
   tpsc_pkg::lane_ctl_type         div_ctl;

   // the pipe never backs up; hold requests off only while reset flushes it
   assign busy   = reset;
   assign accept = start && !busy;

   tpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // select the channel's points, form the slope product and scale it
   tpsc_prep #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_action (req_action),
      .in_raw    (req_raw_sample),
      .cfg       (cfg),
      .out_valid (prep_valid),
      .out_num   (prep_num),
      .out_dmag  (prep_dmag),
      .out_y0s   (prep_y0s),
      .out_ctl   (prep_ctl)
   );

   // magnitude divide; the scaled offset rides along untouched
   tpsc_div #(
      .NUM_W  (NUM_W),
      .QUOT_W (QUOT_W),
      .PASS_W (Y0S_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_num    (prep_num),
      .in_dmag   (prep_dmag),
      .in_pass   (prep_y0s),
      .in_ctl    (prep_ctl),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_pass  (div_y0s),
      .out_ctl   (div_ctl)
   );

   // apply sign and offset, clamp, register the result strobe
   tpsc_post #(
      .FRACTION_BITS (FRACTION_BITS),
      .QUOT_W        (QUOT_W)
   ) u_post (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (div_valid),
      .in_quot     (div_quot),
      .in_y0s      (div_y0s),
      .in_ctl      (div_ctl),
      .out_valid   (rsp_valid),
      .out_value   (rsp_calibrated_value),
      .out_limited (rsp_limited),
      .out_error   (rsp_divide_error)
   );

endmodule

`default_nettype wire

FILE: rtl/tpsc_csr.sv
// Calibration register file of the two-point sensor calibration block.
// Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [tpsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tpsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tpsc_pkg::cal_cfg_type                 cfg
);

   tpsc_pkg::cal_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (tpsc_pkg::csr_index_type'(csr_index))
            tpsc_pkg::CSR_HUM_POINT0_PCT: begin
               cfg_in.hum_point0_pct = csr_wdata[tpsc_pkg::HUM_PCT_W-1:0];
            end
            tpsc_pkg::CSR_HUM_POINT1_PCT: begin
               cfg_in.hum_point1_pct = csr_wdata[tpsc_pkg::HUM_PCT_W-1:0];
            end
            tpsc_pkg::CSR_HUM_POINT0_RAW: begin
               cfg_in.hum_point0_raw = signed'(csr_wdata[tpsc_pkg::RAW_W-1:0]);
            end
            tpsc_pkg::CSR_HUM_POINT1_RAW: begin
               cfg_in.hum_point1_raw = signed'(csr_wdata[tpsc_pkg::RAW_W-1:0]);
            end
            tpsc_pkg::CSR_TEMP_POINT0_X8: begin
               cfg_in.temp_point0_x8 = csr_wdata[tpsc_pkg::TEMP_X8_W-1:0];
            end
            tpsc_pkg::CSR_TEMP_POINT1_X8: begin
               cfg_in.temp_point1_x8 = csr_wdata[tpsc_pkg::TEMP_X8_W-1:0];
            end
            tpsc_pkg::CSR_TEMP_POINT0_RAW: begin
               cfg_in.temp_point0_raw = signed'(csr_wdata[tpsc_pkg::RAW_W-1:0]);
            end
            tpsc_pkg::CSR_TEMP_POINT1_RAW: begin
               cfg_in.temp_point1_raw = signed'(csr_wdata[tpsc_pkg::RAW_W-1:0]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tpsc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/tpsc_prep.sv
// Front of the calibration pipe: point select and differences, slope
// product, magnitude and fixed-point scaling. Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_prep #(
   parameter int FRACTION_BITS = tpsc_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       in_valid,
   input  wire logic                                       in_action,
   input  wire logic signed [tpsc_pkg::RAW_W-1:0]          in_raw,
   input  wire tpsc_pkg::cal_cfg_type                      cfg,
   output logic                                            out_valid,
   output logic [tpsc_pkg::PMAG_W+FRACTION_BITS-1:0]       out_num,
   output logic [tpsc_pkg::DEN_W-1:0]                      out_dmag,
   output logic [tpsc_pkg::HUM_PCT_W+FRACTION_BITS-1:0]    out_y0s,
   output tpsc_pkg::lane_ctl_type                          out_ctl
);

   localparam int NUM_W   = tpsc_pkg::PMAG_W + FRACTION_BITS;
   localparam int Y0S_W   = tpsc_pkg::HUM_PCT_W + FRACTION_BITS;
   localparam int SHIFT_T = FRACTION_BITS - tpsc_pkg::TEMP_POINT_SHIFT;

   // stage A: differences
   logic                                   a_valid_ff;
   logic                                   a_action_ff;
   logic        [tpsc_pkg::POINT_W-1:0]    a_y0_ff, a_y0_in;
   logic signed [tpsc_pkg::DY_W-1:0]       a_dy_ff, a_dy_in;
   logic signed [tpsc_pkg::DX_W-1:0]       a_dx_ff, a_dx_in;
   logic signed [tpsc_pkg::DX_W-1:0]       a_den_ff, a_den_in;
   logic        [tpsc_pkg::POINT_W-1:0]    sel_y1;
   logic signed [tpsc_pkg::RAW_W-1:0]      sel_x0, sel_x1;

   always_comb begin
      if (in_action == tpsc_pkg::ACTION_TEMPERATURE) begin
         a_y0_in = cfg.temp_point0_x8;
         sel_y1  = cfg.temp_point1_x8;
         sel_x0  = cfg.temp_point0_raw;
         sel_x1  = cfg.temp_point1_raw;
      end else begin
         a_y0_in = tpsc_pkg::POINT_W'(cfg.hum_point0_pct);
         sel_y1  = tpsc_pkg::POINT_W'(cfg.hum_point1_pct);
         sel_x0  = cfg.hum_point0_raw;
         sel_x1  = cfg.hum_point1_raw;
      end
      a_dy_in  = signed'({1'b0, sel_y1}) - signed'({1'b0, a_y0_in});
      a_dx_in  = tpsc_pkg::DX_W'(in_raw) - tpsc_pkg::DX_W'(sel_x0);
      a_den_in = tpsc_pkg::DX_W'(sel_x1) - tpsc_pkg::DX_W'(sel_x0);
   end

   always_ff @(posedge clock) begin
      a_action_ff <= in_action;
      a_y0_ff     <= a_y0_in;
      a_dy_ff     <= a_dy_in;
      a_dx_ff     <= a_dx_in;
      a_den_ff    <= a_den_in;
   end

   // stage B: slope product, denominator magnitude
   logic                                   b_valid_ff;
   logic                                   b_action_ff;
   logic        [tpsc_pkg::POINT_W-1:0]    b_y0_ff;
   logic signed [tpsc_pkg::PROD_W-1:0]     b_prod_ff, b_prod_in;
   logic signed [tpsc_pkg::DX_W-1:0]       den_abs;
   logic        [tpsc_pkg::DEN_W-1:0]      b_dmag_ff;
   logic                                   b_den_neg_ff;
   logic                                   b_bad_ff;

   assign b_prod_in = tpsc_pkg::PROD_W'(a_dy_ff) * tpsc_pkg::PROD_W'(a_dx_ff);
   assign den_abs   = a_den_ff[tpsc_pkg::DX_W-1] ? -a_den_ff : a_den_ff;

   always_ff @(posedge clock) begin
      b_action_ff  <= a_action_ff;
      b_y0_ff      <= a_y0_ff;
      b_prod_ff    <= b_prod_in;
      b_dmag_ff    <= den_abs[tpsc_pkg::DEN_W-1:0];
      b_den_neg_ff <= a_den_ff[tpsc_pkg::DX_W-1];
      b_bad_ff     <= (a_den_ff == '0);
   end

   // stage C: magnitude and scaling by the channel's fraction shift
   logic signed [tpsc_pkg::PROD_W-1:0]     prod_abs;
   logic        [tpsc_pkg::PMAG_W-1:0]     pmag;
   logic                                   c_valid_ff;
   logic        [NUM_W-1:0]                c_num_ff, c_num_in;
   logic        [Y0S_W-1:0]                c_y0s_ff, c_y0s_in;
   logic        [tpsc_pkg::DEN_W-1:0]      c_dmag_ff;
   tpsc_pkg::lane_ctl_type                 c_ctl_ff, c_ctl_in;

   assign prod_abs = b_prod_ff[tpsc_pkg::PROD_W-1] ? -b_prod_ff : b_prod_ff;
   assign pmag     = prod_abs[tpsc_pkg::PMAG_W-1:0];

   always_comb begin
      if (b_action_ff == tpsc_pkg::ACTION_TEMPERATURE) begin
         c_num_in = NUM_W'(pmag) << SHIFT_T;
         c_y0s_in = Y0S_W'(b_y0_ff) << SHIFT_T;
      end else begin
         c_num_in = NUM_W'(pmag) << FRACTION_BITS;
         c_y0s_in = Y0S_W'(b_y0_ff) << FRACTION_BITS;
      end
      c_ctl_in.action = b_action_ff;
      c_ctl_in.bad    = b_bad_ff;
      c_ctl_in.qneg   = b_prod_ff[tpsc_pkg::PROD_W-1] ^ b_den_neg_ff;
      c_ctl_in.ovf    = 1'b0;
   end

   always_ff @(posedge clock) begin
      c_num_ff  <= c_num_in;
      c_y0s_ff  <= c_y0s_in;
      c_dmag_ff <= b_dmag_ff;
      c_ctl_ff  <= c_ctl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_num   = c_num_ff;
   assign out_dmag  = c_dmag_ff;
   assign out_y0s   = c_y0s_ff;
   assign out_ctl   = c_ctl_ff;

endmodule

`default_nettype wire

FILE: rtl/tpsc_div.sv
// Pipelined restoring divider of the calibration block: one quotient bit per
// stage; it flags overflow, and tpsc_post caps the quotient. Uses tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_div #(
   parameter int NUM_W  = 34,
   parameter int QUOT_W = 17,
   parameter int PASS_W = 15
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [NUM_W-1:0]                  in_num,
   input  wire logic [tpsc_pkg::DEN_W-1:0]        in_dmag,
   input  wire logic [PASS_W-1:0]                 in_pass,
   input  wire tpsc_pkg::lane_ctl_type            in_ctl,
   output logic                                   out_valid,
   output logic [QUOT_W-1:0]                      out_quot,
   output logic [PASS_W-1:0]                      out_pass,
   output tpsc_pkg::lane_ctl_type                 out_ctl
);

   localparam int DEN_W = tpsc_pkg::DEN_W;
   localparam int HI_W  = NUM_W - QUOT_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   // stage 0 loads; stages 1..QUOT_W each retire one quotient bit.
   // w holds the unconsumed dividend bits on top and the quotient below.
   logic                             valid_ff [0:QUOT_W];
   logic [DEN_W-1:0]                 r_ff     [0:QUOT_W];
   logic [DEN_W-1:0]                 r_in     [0:QUOT_W];
   logic [QUOT_W-1:0]                w_ff     [0:QUOT_W];
   logic [QUOT_W-1:0]                w_in     [0:QUOT_W];
   logic [DEN_W-1:0]                 dmag_ff  [0:QUOT_W];
   logic [PASS_W-1:0]                pass_ff  [0:QUOT_W];
   tpsc_pkg::lane_ctl_type           ctl_ff   [0:QUOT_W];
   tpsc_pkg::lane_ctl_type           ctl_in0;
   logic [DEN_W:0]                   trial    [1:QUOT_W];
   logic [DEN_W:0]                   diff     [1:QUOT_W];
   logic                             ge       [1:QUOT_W];
   logic [CMP_W-1:0]                 hi_x, den_x;

   // quotient fits in QUOT_W bits exactly when the dividend's top part is
   // below the divisor; then that top part is the first partial remainder
   assign hi_x = CMP_W'(in_num[NUM_W-1:QUOT_W]);
   assign den_x = CMP_W'(in_dmag);

   always_comb begin
      r_in[0]     = hi_x[DEN_W-1:0];
      w_in[0]     = in_num[QUOT_W-1:0];
      ctl_in0     = in_ctl;
      ctl_in0.ovf = (hi_x >= den_x);
      for (int s = 1; s <= QUOT_W; s++) begin
         trial[s] = {r_ff[s-1], w_ff[s-1][QUOT_W-1]};
         diff[s]  = trial[s] - {1'b0, dmag_ff[s-1]};
         ge[s]    = (trial[s] >= {1'b0, dmag_ff[s-1]});
         r_in[s]  = ge[s] ? diff[s][DEN_W-1:0] : trial[s][DEN_W-1:0];
         w_in[s]  = {w_ff[s-1][QUOT_W-2:0], ge[s]};
      end
   end

   always_ff @(posedge clock) begin
      r_ff[0]    <= r_in[0];
      w_ff[0]    <= w_in[0];
      dmag_ff[0] <= in_dmag;
      pass_ff[0] <= in_pass;
      ctl_ff[0]  <= ctl_in0;
      for (int s = 1; s <= QUOT_W; s++) begin
         r_ff[s]    <= r_in[s];
         w_ff[s]    <= w_in[s];
         dmag_ff[s] <= dmag_ff[s-1];
         pass_ff[s] <= pass_ff[s-1];
         ctl_ff[s]  <= ctl_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUOT_W; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= QUOT_W; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W];
   assign out_quot  = w_ff[QUOT_W];
   assign out_pass  = pass_ff[QUOT_W];
   assign out_ctl   = ctl_ff[QUOT_W];

endmodule

`default_nettype wire

FILE: rtl/tpsc_post.sv
// Back of the calibration pipe: signed quotient plus scaled offset, then
// humidity clamp, output saturation and result register. Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_post #(
   parameter int FRACTION_BITS = tpsc_pkg::FRACTION_BITS_DEFAULT,
   parameter int QUOT_W        = 17
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       in_valid,
   input  wire logic [QUOT_W-1:0]                          in_quot,
   input  wire logic [tpsc_pkg::HUM_PCT_W+FRACTION_BITS-1:0] in_y0s,
   input  wire tpsc_pkg::lane_ctl_type                     in_ctl,
   output logic                                            out_valid,
   output logic signed [tpsc_pkg::OUT_W-1:0]               out_value,
   output logic                                            out_limited,
   output logic                                            out_error
);

   localparam int VW    = QUOT_W + 2;
   localparam int Y0S_W = tpsc_pkg::HUM_PCT_W + FRACTION_BITS;
   localparam logic signed [VW-1:0] HUM_TOP = VW'(tpsc_pkg::HUM_FULL_SCALE << FRACTION_BITS);
   localparam logic signed [VW-1:0] OUT_MAX = VW'((1 << (tpsc_pkg::OUT_W - 1)) - 1);
   localparam logic signed [VW-1:0] OUT_MIN = VW'(-(1 << (tpsc_pkg::OUT_W - 1)));
   localparam logic signed [VW-1:0] ZERO    = '0;

   // stage E: offset add
   logic        [QUOT_W-1:0]   q_cap;
   logic signed [VW-1:0]       q_v, y0_v;
   logic                       e_valid_ff;
   logic signed [VW-1:0]       e_val_ff, e_val_in;
   logic                       e_action_ff;
   logic                       e_bad_ff;

   assign q_cap    = in_ctl.ovf ? '1 : in_quot;
   assign q_v      = signed'({{(VW - QUOT_W){1'b0}}, q_cap});
   assign y0_v     = signed'({{(VW - Y0S_W){1'b0}}, in_y0s});
   assign e_val_in = in_ctl.qneg ? (y0_v - q_v) : (y0_v + q_v);

   always_ff @(posedge clock) begin
      e_val_ff    <= e_val_in;
      e_action_ff <= in_ctl.action;
      e_bad_ff    <= in_ctl.bad;
   end

   // stage F: clamp and saturate
   logic signed [VW-1:0]           h_val, s_val;
   logic                           h_lim, s_lim;
   logic                           f_valid_ff;
   logic signed [tpsc_pkg::OUT_W-1:0] f_value_ff, f_value_in;
   logic                           f_limited_ff, f_limited_in;
   logic                           f_error_ff;

   always_comb begin
      h_val = e_val_ff;
      h_lim = 1'b0;
      if (e_action_ff != tpsc_pkg::ACTION_TEMPERATURE) begin
         if (e_val_ff < ZERO) begin
            h_val = ZERO;
            h_lim = 1'b1;
         end else if (e_val_ff > HUM_TOP) begin
            h_val = HUM_TOP;
            h_lim = 1'b1;
         end
      end
      s_val = h_val;
      s_lim = h_lim;
      if (h_val > OUT_MAX) begin
         s_val = OUT_MAX;
         s_lim = 1'b1;
      end else if (h_val < OUT_MIN) begin
         s_val = OUT_MIN;
         s_lim = 1'b1;
      end
      // equal raw points: drop the arithmetic, report zero
      if (e_bad_ff) begin
         f_value_in   = '0;
         f_limited_in = 1'b0;
      end else begin
         f_value_in   = s_val[tpsc_pkg::OUT_W-1:0];
         f_limited_in = s_lim;
      end
   end

   always_ff @(posedge clock) begin
      f_value_ff   <= f_value_in;
      f_limited_ff <= f_limited_in;
      f_error_ff   <= e_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= in_valid;
         f_valid_ff <= e_valid_ff;
      end
   end

   assign out_valid   = f_valid_ff;
   assign out_value   = f_value_ff;
   assign out_limited = f_limited_ff;
   assign out_error   = f_error_ff;

endmodule

`default_nettype wire

FILE: rtl/tpsc_check.sv
// Port-level checker for the two-point sensor calibration block, with the
// bind that attaches it to the top level. Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_check #(
   parameter int FRACTION_BITS = tpsc_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                req_action,
   input  wire logic                                rsp_valid,
   input  wire logic signed [tpsc_pkg::OUT_W-1:0]   rsp_calibrated_value,
   input  wire logic                                rsp_limited,
   input  wire logic                                rsp_divide_error
);

   localparam int LAT = tpsc_pkg::pipe_latency(FRACTION_BITS);
   localparam int HUM_TOP_INT = tpsc_pkg::HUM_FULL_SCALE << FRACTION_BITS;
   localparam int OUT_MAX_INT = (1 << (tpsc_pkg::OUT_W - 1)) - 1;
   localparam logic signed [tpsc_pkg::OUT_W-1:0] OUT_MAX = tpsc_pkg::OUT_W'(OUT_MAX_INT);
   localparam logic signed [tpsc_pkg::OUT_W-1:0] OUT_MIN = tpsc_pkg::OUT_W'(-OUT_MAX_INT - 1);
   localparam logic signed [tpsc_pkg::OUT_W-1:0] HUM_CAP =
      tpsc_pkg::OUT_W'((HUM_TOP_INT > OUT_MAX_INT) ? OUT_MAX_INT : HUM_TOP_INT);
   localparam logic signed [tpsc_pkg::OUT_W-1:0] ZERO = '0;

   // expected strobe and channel, delayed by the pipe depth
   logic [LAT-1:0] exp_valid_ff, exp_valid_in;
   logic [LAT-1:0] exp_act_ff, exp_act_in;
   logic           rsp_hum, rsp_temp;

   assign exp_valid_in = {exp_valid_ff[LAT-2:0], start && !busy};
   assign exp_act_in   = {exp_act_ff[LAT-2:0], req_action};
   assign rsp_temp     = rsp_valid && !rsp_divide_error &&
                         (exp_act_ff[LAT-1] == tpsc_pkg::ACTION_TEMPERATURE);
   assign rsp_hum      = rsp_valid && !rsp_divide_error &&
                         (exp_act_ff[LAT-1] != tpsc_pkg::ACTION_TEMPERATURE);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= '0;
      end else begin
         exp_valid_ff <= exp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_act_ff <= exp_act_in;
   end

   a_one_result_per_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == exp_valid_ff[LAT-1])
      else $error("result strobe does not match accepted requests");

   a_divide_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> (rsp_calibrated_value == ZERO) && !rsp_limited)
      else $error("divide error result is not a clean zero");

   a_humidity_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_hum |-> (rsp_calibrated_value >= ZERO) && (rsp_calibrated_value <= HUM_CAP))
      else $error("humidity result outside its clamp range");

   a_humidity_limit_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_hum && rsp_limited |-> (rsp_calibrated_value == ZERO) ||
                                 (rsp_calibrated_value == HUM_CAP))
      else $error("limited humidity result is not at a clamp bound");

   a_temperature_limit_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_temp && rsp_limited |-> (rsp_calibrated_value == OUT_MAX) ||
                                  (rsp_calibrated_value == OUT_MIN))
      else $error("limited temperature result is not at a saturation bound");

endmodule

bind two_point_sensor_calibration tpsc_check #(
   .FRACTION_BITS (FRACTION_BITS)
) u_tpsc_check (.*);

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for two_point_sensor_calibration: directed table, then random requests
// across calibration settings. Each result is checked against its table row or a local
// interpolation predictor. Depends on tpsc_pkg and the two_point_sensor_calibration RTL.
`timescale 1ns / 1ps

module tb;
   import tpsc_pkg::*;

   localparam int FRAC           = FRACTION_BITS_DEFAULT;
   localparam int LATENCY        = pipe_latency(FRAC);
   localparam int CLOCK_PERIOD   = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int PHASES         = 12;
   localparam int PHASE_REQUESTS = 150;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DIRECTED_ROWS  = 31;

   localparam logic ACTION_HUMIDITY = 1'b0;

   // one calibrated reading as the result channel shows it
   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    limited;
      logic                    divide_error;
   } reading_type;

   localparam reading_type NO_READING = '0;

   typedef enum {ROW_REQUEST, ROW_WRITE} row_kind_type;
   typedef enum {CAL_TYPICAL, CAL_RANDOM, CAL_EXTREME, CAL_FLAT} cal_kind_type;

   // one line of the directed table: either a register write or a request;
   // a request with typed set carries its expected reading, otherwise the
   // predictor works it out
   typedef struct {
      row_kind_type              kind;
      csr_index_type             index;
      logic [CSR_DATA_W-1:0]     wdata;
      logic                      action;
      logic signed [RAW_W-1:0]   raw;
      bit                        typed;
      reading_type               want;
   } stim_row_type;

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        start          = 1'b0;
   logic                        busy;
   logic                        req_action     = 1'b0;
   logic signed [RAW_W-1:0]     req_raw_sample = '0;
   logic                        rsp_valid;
   logic signed [OUT_W-1:0]     rsp_calibrated_value;
   logic                        rsp_limited;
   logic                        rsp_divide_error;
   logic                        csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index      = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata      = '0;

   // local copy of the calibration registers
   cal_cfg_type cal;

   reading_type expected_readings[$];
   int          mismatch_count  = 0;
   int          sender_idle_pct = 26;

   // expectation attached to the request now on the ports
   bit          cur_typed = 1'b0;
   reading_type cur_want  = NO_READING;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset calibration: humidity 0..100 % over raw 0..1
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sd0, 1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sd1, 1'b1,
        '{16'sd25600, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, -16'sd1, 1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sh7FFF, 1'b1,
        '{16'sd25600, 1'b1, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sh8000, 1'b1,
        '{16'sd0, 1'b1, 1'b0}},
      // reset calibration: temperature 256 per raw count, saturating
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sd0, 1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sd1, 1'b1,
        '{16'sd256, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sd127, 1'b1,
        '{16'sd32512, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sd128, 1'b1,
        '{16'sh7FFF, 1'b1, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, -16'sd128, 1'b1,
        '{16'sh8000, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, -16'sd129, 1'b1,
        '{16'sh8000, 1'b1, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sh7FFF, 1'b1,
        '{16'sh7FFF, 1'b1, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sh8000, 1'b1,
        '{16'sh8000, 1'b1, 1'b0}},
      // equal raw points on both channels
      '{ROW_WRITE, CSR_HUM_POINT1_RAW, 16'h0000, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_TEMP_POINT1_RAW, 16'h0000, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sd5, 1'b1,
        '{16'sd0, 1'b0, 1'b1}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, -16'sd7, 1'b1,
        '{16'sd0, 1'b0, 1'b1}},
      // full-scale points with falling slope; upper data bits of narrow
      // registers must be dropped
      '{ROW_WRITE, CSR_HUM_POINT0_PCT, 16'hFF7F, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_HUM_POINT1_PCT, 16'h0000, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_HUM_POINT0_RAW, 16'h8000, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_HUM_POINT1_RAW, 16'h7FFF, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_TEMP_POINT0_X8, 16'hFFFF, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_TEMP_POINT1_X8, 16'h0000, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_TEMP_POINT0_RAW, 16'h8000, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_WRITE, CSR_TEMP_POINT1_RAW, 16'h7FFF, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sh8000, 1'b1,
        '{16'sd25600, 1'b1, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sh7FFF, 1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_HUMIDITY, 16'sd0, 1'b0, NO_READING},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sh8000, 1'b1,
        '{16'sd32736, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sh7FFF, 1'b1,
        '{16'sd0, 1'b0, 1'b0}},
      '{ROW_REQUEST, CSR_HUM_POINT0_PCT, 16'h0, ACTION_TEMPERATURE, 16'sd1234, 1'b0,
        NO_READING}
   };

   two_point_sensor_calibration #(
      .FRACTION_BITS(FRAC)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_raw_sample(req_raw_sample),
      .rsp_valid(rsp_valid),
      .rsp_calibrated_value(rsp_calibrated_value),
      .rsp_limited(rsp_limited),
      .rsp_divide_error(rsp_divide_error),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Interpolate between the two points of the selected channel with exact
   // integers, truncate the quotient toward zero, then clamp humidity to
   // 0..100 % and saturate everything to the 16-bit output.
   function automatic reading_type predict_reading(input logic action,
                                                   input logic signed [RAW_W-1:0] raw);
      longint      y0, y1, x0, x1, scale, span, val;
      longint      full_scale;
      reading_type r;
      r = NO_READING;
      full_scale = longint'(HUM_FULL_SCALE) << FRAC;
      if (action == ACTION_TEMPERATURE) begin
         y0    = longint'(cal.temp_point0_x8);
         y1    = longint'(cal.temp_point1_x8);
         x0    = longint'(cal.temp_point0_raw);
         x1    = longint'(cal.temp_point1_raw);
         scale = longint'(1) << (FRAC - TEMP_POINT_SHIFT);
      end else begin
         y0    = longint'(cal.hum_point0_pct);
         y1    = longint'(cal.hum_point1_pct);
         x0    = longint'(cal.hum_point0_raw);
         x1    = longint'(cal.hum_point1_raw);
         scale = longint'(1) << FRAC;
      end
      span = x1 - x0;
      // equal raw points: zero value, divide error, no limit flag
      if (span == 0) begin
         r.divide_error = 1'b1;
         return r;
      end
      val = y0 * scale + ((y1 - y0) * (longint'(raw) - x0) * scale) / span;
      if (action != ACTION_TEMPERATURE) begin
         if (val < 0) begin
            val       = 0;
            r.limited = 1'b1;
         end else if (val > full_scale) begin
            val       = full_scale;
            r.limited = 1'b1;
         end
      end
      if (val > 32767) begin
         val       = 32767;
         r.limited = 1'b1;
      end else if (val < -32768) begin
         val       = -32768;
         r.limited = 1'b1;
      end
      r.value = OUT_W'(val);
      return r;
   endfunction

   // Pick a raw sample: mostly around the channel's calibration span, where
   // the interpolation is live, the rest anywhere in the 16-bit range.
   function automatic logic signed [RAW_W-1:0] pick_raw_sample(input logic action);
      int x0, x1, lo, hi;
      if (action == ACTION_TEMPERATURE) begin
         x0 = int'(cal.temp_point0_raw);
         x1 = int'(cal.temp_point1_raw);
      end else begin
         x0 = int'(cal.hum_point0_raw);
         x1 = int'(cal.hum_point1_raw);
      end
      if ($urandom_range(99) < 35)
         return RAW_W'($urandom);
      lo = ((x0 < x1) ? x0 : x1) - 256;
      hi = ((x0 < x1) ? x1 : x0) + 256;
      if (lo < -32768)
         lo = -32768;
      if (hi > 32767)
         hi = 32767;
      return RAW_W'(lo + int'($urandom_range(hi - lo)));
   endfunction

   // Write one register and mirror it into the local copy. Called at a
   // falling edge with nothing in flight; returns at a falling edge.
   task automatic write_register(input csr_index_type index, input logic [CSR_DATA_W-1:0] wdata);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      case (index)
         CSR_HUM_POINT0_PCT:  cal.hum_point0_pct  = wdata[HUM_PCT_W-1:0];
         CSR_HUM_POINT1_PCT:  cal.hum_point1_pct  = wdata[HUM_PCT_W-1:0];
         CSR_HUM_POINT0_RAW:  cal.hum_point0_raw  = wdata[RAW_W-1:0];
         CSR_HUM_POINT1_RAW:  cal.hum_point1_raw  = wdata[RAW_W-1:0];
         CSR_TEMP_POINT0_X8:  cal.temp_point0_x8  = wdata[TEMP_X8_W-1:0];
         CSR_TEMP_POINT1_X8:  cal.temp_point1_x8  = wdata[TEMP_X8_W-1:0];
         CSR_TEMP_POINT0_RAW: cal.temp_point0_raw = wdata[RAW_W-1:0];
         CSR_TEMP_POINT1_RAW: cal.temp_point1_raw = wdata[RAW_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      // drop the enable a full cycle so back-to-back writes never stack
      // two assignments on csr_we in one step
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Drop start and hold until every outstanding request has answered.
   // Always advances at least one falling edge.
   task automatic wait_until_drained();
      start <= 1'b0;
      do
         @(negedge clock);
      while (expected_readings.size() != 0);
   endtask

   // Present one request, idling the sender at random first, and hold it
   // until the block takes it. Called and returns at a falling edge.
   task automatic send_request(input logic action, input logic signed [RAW_W-1:0] raw,
                               input bit typed, input reading_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_action     <= action;
      req_raw_sample <= raw;
      cur_typed       = typed;
      cur_want        = want;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Load a whole calibration setting. Typical settings keep the points in
   // their usual order with a modest raw span (either slope); random
   // settings fill every data bit; extreme settings pin every register to
   // a range end; flat settings give one channel equal raw points.
   task automatic load_calibration(input cal_kind_type kind);
      int  hx0, tx0;
      int  hspan, tspan;
      bit  swap;
      swap = 1'($urandom_range(1));
      case (kind)
         CAL_RANDOM: begin
            write_register(CSR_HUM_POINT0_PCT,  CSR_DATA_W'($urandom));
            write_register(CSR_HUM_POINT1_PCT,  CSR_DATA_W'($urandom));
            write_register(CSR_HUM_POINT0_RAW,  CSR_DATA_W'($urandom));
            write_register(CSR_HUM_POINT1_RAW,  CSR_DATA_W'($urandom));
            write_register(CSR_TEMP_POINT0_X8,  CSR_DATA_W'($urandom));
            write_register(CSR_TEMP_POINT1_X8,  CSR_DATA_W'($urandom));
            write_register(CSR_TEMP_POINT0_RAW, CSR_DATA_W'($urandom));
            write_register(CSR_TEMP_POINT1_RAW, CSR_DATA_W'($urandom));
         end
         CAL_EXTREME: begin
            write_register(CSR_HUM_POINT0_PCT,  swap ? 16'h007F : 16'h0000);
            write_register(CSR_HUM_POINT1_PCT,  swap ? 16'h0000 : 16'h007F);
            write_register(CSR_HUM_POINT0_RAW,  16'h8000);
            write_register(CSR_HUM_POINT1_RAW,  16'h7FFF);
            write_register(CSR_TEMP_POINT0_X8,  swap ? 16'h0000 : 16'h03FF);
            write_register(CSR_TEMP_POINT1_X8,  swap ? 16'h03FF : 16'h0000);
            write_register(CSR_TEMP_POINT0_RAW, 16'h7FFF);
            write_register(CSR_TEMP_POINT1_RAW, 16'h8000);
         end
         default: begin
            hx0   = int'($urandom_range(65535)) - 32768;
            tx0   = int'($urandom_range(65535)) - 32768;
            hspan = $urandom_range(1, 6000);
            tspan = $urandom_range(1, 6000);
            // flip the slope half the time
            if ($urandom_range(1))
               hspan = -hspan;
            if ($urandom_range(1))
               tspan = -tspan;
            write_register(CSR_HUM_POINT0_PCT,  CSR_DATA_W'($urandom_range(30)));
            write_register(CSR_HUM_POINT1_PCT,  CSR_DATA_W'($urandom_range(70, 127)));
            write_register(CSR_HUM_POINT0_RAW,  CSR_DATA_W'(hx0));
            write_register(CSR_HUM_POINT1_RAW,  CSR_DATA_W'(hx0 + hspan));
            write_register(CSR_TEMP_POINT0_X8,  CSR_DATA_W'($urandom_range(400)));
            write_register(CSR_TEMP_POINT1_X8,  CSR_DATA_W'($urandom_range(400, 1023)));
            write_register(CSR_TEMP_POINT0_RAW, CSR_DATA_W'(tx0));
            write_register(CSR_TEMP_POINT1_RAW, CSR_DATA_W'(tx0 + tspan));
            if (kind == CAL_FLAT) begin
               if (swap)
                  write_register(CSR_TEMP_POINT1_RAW, CSR_DATA_W'(tx0));
               else
                  write_register(CSR_HUM_POINT1_RAW, CSR_DATA_W'(hx0));
            end
         end
      endcase
   endtask

   // Scoreboard: record the expected reading of each request taken and
   // compare every strobed result against the oldest record.
   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               $error("result strobed with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_calibrated_value !== want.value) begin
                  $error("calibrated_value: expected %0d, actual %0d",
                         want.value, rsp_calibrated_value);
                  mismatch_count++;
               end
               if (rsp_limited !== want.limited) begin
                  $error("limited: expected %0d, actual %0d", want.limited, rsp_limited);
                  mismatch_count++;
               end
               if (rsp_divide_error !== want.divide_error) begin
                  $error("divide_error: expected %0d, actual %0d",
                         want.divide_error, rsp_divide_error);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            expected_readings.push_back(cur_typed ? cur_want
                                                  : predict_reading(req_action, req_raw_sample));
      end
   end

   initial begin
      logic action;
      // mirror the reset values of the calibration registers
      cal = '{7'd0, 7'd100, 16'sd0, 16'sd1, 10'd0, 10'd8, 16'sd0, 16'sd1};

      // hold reset, then release it at a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table; drain before each register write
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_until_drained();
            write_register(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            send_request(directed_rows[i].action, directed_rows[i].raw,
                         directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random phases: sender idles often, then more, then never;
      // reload the calibration between phases once the pipe is empty
      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle_pct = (phase < PHASES / 3) ? 26 : (phase < 2 * PHASES / 3) ? 46 : 0;
         wait_until_drained();
         load_calibration(cal_kind_type'(phase % 4));
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            action = 1'($urandom_range(1));
            send_request(action, pick_raw_sample(action), 1'b0, NO_READING);
         end
      end

      // drain, then give stray results a window to show up
      wait_until_drained();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
rtl/tpsc_pkg.sv
rtl/tpsc_csr.sv
rtl/tpsc_prep.sv
rtl/tpsc_div.sv
rtl/tpsc_post.sv
rtl/two_point_sensor_calibration.sv
rtl/tpsc_check.sv
test/tb.sv
